// ===== design/hsct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_pkg
// Types and constants shared by the hard sphere collision time pipeline.
// ----------------------------------------------------------------------------
package hsct_pkg;

	localparam int CFG_W  = 31;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_BOX_X = 3'd0,
		REG_BOX_Y = 3'd1,
		REG_BOX_Z = 3'd2,
		REG_DIAM  = 3'd3,
		REG_SLIT  = 3'd4
	} reg_idx_t;

	localparam logic [CFG_W-1:0] BOX_RESET = 31'd655360;
	localparam logic [CFG_W-1:0] DIA_RESET = 31'd65536;

	localparam int T_W = 25;
	localparam logic [T_W-1:0] NO_HIT_TIME = 25'd19660800;

	localparam int POS_W  = 32;
	localparam int DIF_W  = 33;   // raw difference
	localparam int DR_W   = 35;   // wrapped separation
	localparam int MAG_W  = 34;   // per-axis magnitude into first multiplier
	localparam int P1_W   = 2 * MAG_W;
	localparam int B_W    = 70;
	localparam int VV_W   = 68;
	localparam int RRD_W  = 71;
	localparam int M2_W   = 70;
	localparam int P2_W   = 2 * M2_W;
	localparam int DISC_W = 142;
	localparam int RAD_W  = 140;
	localparam int ROOT_W = RAD_W / 2;
	localparam int FRAC_W = 16;
	localparam int SCL_W  = B_W + FRAC_W;

	typedef struct packed {
		logic            b_neg;
		logic            rrd_neg;
		logic [VV_W-1:0] vv;
		logic [B_W-1:0]  b_mag;
	} m2_tag_t;

	typedef struct packed {
		logic            hit;
		logic [VV_W-1:0] vv;
		logic [B_W-1:0]  b_mag;
	} sq_tag_t;

	typedef struct packed {
		logic hit;
		logic num_neg;
	} dv_tag_t;

endpackage

// ===== design/hsct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_in_if / hsct_out_if
// Valid/ready channels for sphere pairs and collision results.
// ----------------------------------------------------------------------------
interface hsct_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] first_vx;
	logic signed [31:0] first_vy;
	logic signed [31:0] first_vz;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;
	logic signed [31:0] second_vx;
	logic signed [31:0] second_vy;
	logic signed [31:0] second_vz;

	modport source(output valid, first_x, first_y, first_z, first_vx, first_vy, first_vz,
		second_x, second_y, second_z, second_vx, second_vy, second_vz, input ready);
	modport sink(input valid, first_x, first_y, first_z, first_vx, first_vy, first_vz,
		second_x, second_y, second_z, second_vx, second_vy, second_vz, output ready);
endinterface

interface hsct_out_if;
	logic        valid;
	logic        ready;
	logic [24:0] collision_time;
	logic        will_collide;

	modport source(output valid, collision_time, will_collide, input ready);
	modport sink(input valid, collision_time, will_collide, output ready);
endinterface

// ===== design/hard_sphere_collision_time_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hard_sphere_collision_time_top
// Predicts the contact time of two hard spheres in a periodic box.
// ----------------------------------------------------------------------------
// Usage:
//   in_pair carries one sphere pair per item (positions and velocities, signed
//   Q16.16). out_time returns one item per pair: collision_time (unsigned Q9.16,
//   capped at 300.0) and will_collide. Items leave in the order they entered.
//   cfg_we/cfg_index/cfg_wdata write the box lengths, diameter and slit-pore
//   flag; write them only while no pair is in flight.
//   Throughput is one pair per cycle while out_time is not stalled. The
//   pipeline depth is set mostly by the 70-stage square root and the 26-stage
//   divider; the multipliers take one 17-bit operand slice per stage.
//   The whole pipeline advances as one: when out_time holds a result that is
//   not taken, every stage holds and in_pair.ready drops, so nothing is lost.
//   Reset clears all valid bits and loads box lengths 10.0, diameter 1.0 and
//   periodic z.
// ----------------------------------------------------------------------------
module hard_sphere_collision_time_top (
	input  logic                        clk,
	input  logic                        arst_n,
	hsct_in_if.sink                     in_pair,
	hsct_out_if.source                  out_time,
	input  logic                        cfg_we,
	input  logic [hsct_pkg::IDX_W-1:0]  cfg_index,
	input  logic [hsct_pkg::CFG_W-1:0]  cfg_wdata
);
	import hsct_pkg::*;

	// configuration
	logic [CFG_W-1:0] box_q [3];
	logic [CFG_W-1:0] dia_q;
	logic             slit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0] <= BOX_RESET;
			box_q[1] <= BOX_RESET;
			box_q[2] <= BOX_RESET;
			dia_q    <= DIA_RESET;
			slit_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_X: box_q[0] <= cfg_wdata;
				REG_BOX_Y: box_q[1] <= cfg_wdata;
				REG_BOX_Z: box_q[2] <= cfg_wdata;
				REG_DIAM:  dia_q    <= cfg_wdata;
				REG_SLIT:  slit_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;
	logic [T_W-1:0] out_time_q;
	logic out_hit_q;

	assign adv           = !out_valid_q || out_time.ready;
	assign in_pair.ready = adv;

	// S1: raw differences
	logic signed [POS_W-1:0] pa [3], pb [3], va [3], vb [3];
	logic signed [DIF_W-1:0] dr_s1 [3], dv_s1 [3];
	logic v_s1;

	always_comb begin
		pa[0] = in_pair.first_x;   pa[1] = in_pair.first_y;   pa[2] = in_pair.first_z;
		pb[0] = in_pair.second_x;  pb[1] = in_pair.second_y;  pb[2] = in_pair.second_z;
		va[0] = in_pair.first_vx;  va[1] = in_pair.first_vy;  va[2] = in_pair.first_vz;
		vb[0] = in_pair.second_vx; vb[1] = in_pair.second_vy; vb[2] = in_pair.second_vz;
	end

	// S2/S3: minimum image, one correction each way (z is not wrapped in slit-pore mode)
	logic signed [DR_W-1:0]  dr_s2 [3], dr_s3 [3];
	logic signed [DIF_W-1:0] dv_s2 [3], dv_s3 [3];
	logic v_s2, v_s3;
	logic signed [DR_W-1:0]  d2_n [3], d3_n [3], len_e [3];
	logic signed [DR_W:0]    tw2 [3], tw3 [3], len_w [3];
	logic                    wok [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wok[k]   = (k < 2) || !slit_q;
			len_e[k] = $signed({{(DR_W-CFG_W){1'b0}}, box_q[k]});
			len_w[k] = $signed({{(DR_W+1-CFG_W){1'b0}}, box_q[k]});
			d2_n[k]  = DR_W'(dr_s1[k]);
			tw2[k]   = {d2_n[k], 1'b0};
			if (wok[k] && (tw2[k] > len_w[k])) d2_n[k] = d2_n[k] - len_e[k];
			d3_n[k]  = dr_s2[k];
			tw3[k]   = {d3_n[k], 1'b0};
			if (wok[k] && (tw3[k] < -len_w[k])) d3_n[k] = d3_n[k] + len_e[k];
		end
	end

	// S4: magnitudes and product signs
	logic [MAG_W-1:0] drm_s4 [3], dvm_s4 [3];
	logic [2:0]       bsg_s4;
	logic             v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dr_s1[k]  <= DIF_W'(pa[k]) - DIF_W'(pb[k]);
				dv_s1[k]  <= DIF_W'(va[k]) - DIF_W'(vb[k]);
				dr_s2[k]  <= d2_n[k];
				dv_s2[k]  <= dv_s1[k];
				dr_s3[k]  <= d3_n[k];
				dv_s3[k]  <= dv_s2[k];
				drm_s4[k] <= dr_s3[k][DR_W-1] ? MAG_W'(-dr_s3[k]) : MAG_W'(dr_s3[k]);
				dvm_s4[k] <= dv_s3[k][DIF_W-1] ? MAG_W'(-DR_W'(dv_s3[k]))
					: MAG_W'(dv_s3[k]);
				bsg_s4[k] <= dr_s3[k][DR_W-1] ^ dv_s3[k][DIF_W-1];
			end
		end
	end

	// S5-S6: dot products and diameter squared
	localparam int L1 = 10;
	logic [MAG_W-1:0] m1_a [L1], m1_b [L1];
	logic [P1_W-1:0]  m1_p [L1];
	logic [2:0]       m1_sg;
	logic             m1_v;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m1_a[k]   = drm_s4[k]; m1_b[k]   = dvm_s4[k];
			m1_a[3+k] = drm_s4[k]; m1_b[3+k] = drm_s4[k];
			m1_a[6+k] = dvm_s4[k]; m1_b[6+k] = dvm_s4[k];
		end
		m1_a[9] = MAG_W'(dia_q);
		m1_b[9] = MAG_W'(dia_q);
	end

	hsct_mul #(.WA(MAG_W), .WB(MAG_W), .N(L1), .WT(3)) u_mul_dot (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s4),
		.a(m1_a), .b(m1_b), .tag_in(bsg_s4),
		.vout(m1_v), .p(m1_p), .tag_out(m1_sg)
	);

	// S7: sums
	logic signed [B_W-1:0]   b_s7;
	logic [VV_W-1:0]         vv_s7;
	logic signed [RRD_W-1:0] rrd_s7;
	logic                    v_s7;
	logic signed [B_W-1:0]   b_n;
	logic [RRD_W-1:0]        rr_n;
	logic [VV_W-1:0]         vv_n;

	always_comb begin
		b_n  = '0;
		rr_n = '0;
		vv_n = '0;
		for (int k = 0; k < 3; k++) begin
			b_n  = m1_sg[k] ? b_n - B_W'(m1_p[k]) : b_n + B_W'(m1_p[k]);
			rr_n = rr_n + RRD_W'(m1_p[3+k]);
			vv_n = vv_n + VV_W'(m1_p[6+k]);
		end
	end

	// S8: sign split for the squaring stage: -b and the magnitude of rr - d^2
	m2_tag_t          m2_tag_s8;
	logic [M2_W-1:0]  rrdm_s8;
	logic             v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s7 <= m1_v;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s7              <= b_n;
			vv_s7             <= vv_n;
			rrd_s7            <= $signed(rr_n - RRD_W'(m1_p[9]));
			m2_tag_s8.b_neg   <= b_s7[B_W-1];
			m2_tag_s8.b_mag   <= B_W'(-b_s7);
			m2_tag_s8.vv      <= vv_s7;
			m2_tag_s8.rrd_neg <= rrd_s7[RRD_W-1];
			rrdm_s8           <= rrd_s7[RRD_W-1] ? M2_W'(-rrd_s7) : M2_W'(rrd_s7);
		end
	end

	// S9-S13: b^2 and vv*(rr - d^2)
	logic [M2_W-1:0] m2_a [2], m2_b [2];
	logic [P2_W-1:0] m2_p [2];
	m2_tag_t         m2_tag_o;
	logic            m2_v;

	always_comb begin
		m2_a[0] = m2_tag_s8.b_mag;
		m2_b[0] = m2_tag_s8.b_mag;
		m2_a[1] = M2_W'(m2_tag_s8.vv);
		m2_b[1] = rrdm_s8;
	end

	hsct_mul #(.WA(M2_W), .WB(M2_W), .N(2), .WT($bits(m2_tag_t))) u_mul_sq (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s8),
		.a(m2_a), .b(m2_b), .tag_in(m2_tag_s8),
		.vout(m2_v), .p(m2_p), .tag_out(m2_tag_o)
	);

	// S14: discriminant
	logic signed [DISC_W-1:0] disc_n;
	logic                     hit_n;
	logic [RAD_W-1:0]         rad_s14;
	sq_tag_t                  sq_tag_s14;
	logic                     v_s14;

	always_comb begin
		disc_n = m2_tag_o.rrd_neg ? DISC_W'(m2_p[0]) + DISC_W'(m2_p[1])
			: DISC_W'(m2_p[0]) - DISC_W'(m2_p[1]);
		hit_n  = m2_tag_o.b_neg && !disc_n[DISC_W-1] && (disc_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s14 <= 1'b0;
		else if (adv) v_s14 <= m2_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s14          <= hit_n ? disc_n[RAD_W-1:0] : '0;
			sq_tag_s14.hit   <= hit_n;
			sq_tag_s14.vv    <= m2_tag_o.vv;
			sq_tag_s14.b_mag <= m2_tag_o.b_mag;
		end
	end

	// S15-S84: square root
	logic [ROOT_W-1:0] root_o;
	sq_tag_t           sq_tag_o;
	logic              sq_v;

	hsct_sqrt #(.W(RAD_W), .WT($bits(sq_tag_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s14),
		.rad(rad_s14), .tag_in(sq_tag_s14),
		.vout(sq_v), .root(root_o), .tag_out(sq_tag_o)
	);

	// S85: numerator -b - sqrt(disc), shifted left by 16 so that the quotient is Q9.16
	logic signed [B_W:0] num_n;
	logic [SCL_W-1:0]    scl_s85;
	logic [VV_W-1:0]     vv_s85;
	dv_tag_t             dv_tag_s85;
	logic                v_s85;

	assign num_n = $signed({1'b0, sq_tag_o.b_mag}) - $signed({1'b0, B_W'(root_o)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s85 <= 1'b0;
		else if (adv) v_s85 <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scl_s85            <= num_n[B_W] ? '0 : {num_n[B_W-1:0], {FRAC_W{1'b0}}};
			vv_s85             <= sq_tag_o.vv;
			dv_tag_s85.hit     <= sq_tag_o.hit;
			dv_tag_s85.num_neg <= num_n[B_W];
		end
	end

	// S86-S111: division by |dv|^2
	logic [T_W-1:0] quo_o;
	logic           ovf_o;
	dv_tag_t        dv_tag_o;
	logic           dv_v;
	logic [T_W-1:0] t_n;

	hsct_div #(.WN(SCL_W), .WD(VV_W), .QW(T_W), .WT($bits(dv_tag_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s85),
		.num(scl_s85), .den(vv_s85), .tag_in(dv_tag_s85),
		.vout(dv_v), .quo(quo_o), .ovf(ovf_o), .tag_out(dv_tag_o)
	);

	always_comb begin
		if (!dv_tag_o.hit) t_n = NO_HIT_TIME;
		else if (dv_tag_o.num_neg) t_n = '0;  // already overlapping
		else if (ovf_o || (quo_o > NO_HIT_TIME)) t_n = NO_HIT_TIME;
		else t_n = quo_o;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_time_q <= t_n;
			out_hit_q  <= dv_tag_o.hit;
		end
	end

	assign out_time.valid          = out_valid_q;
	assign out_time.collision_time = out_time_q;
	assign out_time.will_collide   = out_hit_q;

`ifndef NO_ASSERTIONS
	a_nohit_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_hit_q) |-> (out_time_q == NO_HIT_TIME))
		else $error("no-collision item without horizon time");

	a_time_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_time_q <= NO_HIT_TIME))
		else $error("collision time above horizon");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_time.ready) |=> ($stable(v_s1) && $stable(v_s14)
			&& $stable(v_s85)))
		else $error("pipeline moved while output stalled");

	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_time.ready) |-> !in_pair.ready)
		else $error("item accepted while output stalled");
`endif

endmodule

// ===== design/hsct_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_mul
// Multi-lane unsigned multiplier, one 17-bit slice of B per pipeline stage.
// ----------------------------------------------------------------------------
module hsct_mul #(
	parameter int WA = 34,
	parameter int WB = 34,
	parameter int N  = 1,
	parameter int WT = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [WA-1:0]       a [N],
	input  logic [WB-1:0]       b [N],
	input  logic [WT-1:0]       tag_in,
	output logic                vout,
	output logic [WA+WB-1:0]    p [N],
	output logic [WT-1:0]       tag_out
);
	localparam int CH  = 17;
	localparam int NST = (WB + CH - 1) / CH;
	localparam int WBP = NST * CH;
	localparam int WP  = WA + WB;

	logic [WA-1:0]    a_s   [NST][N];
	logic [WBP-1:0]   b_s   [NST][N];
	logic [WP-1:0]    acc_s [NST][N];
	logic [WT-1:0]    tag_s [NST];
	logic             v_s   [NST];

	logic [WA-1:0]    a_in   [NST][N];
	logic [WBP-1:0]   b_in   [NST][N];
	logic [WP-1:0]    acc_in [NST][N];
	logic [WA+CH-1:0] prod   [NST][N];
	logic [WP-1:0]    sum_n  [NST][N];
	logic [WT-1:0]    t_in   [NST];
	logic             v_in   [NST];

	always_comb begin
		for (int i = 0; i < NST; i++) begin
			for (int j = 0; j < N; j++) begin
				if (i == 0) begin
					a_in[i][j]   = a[j];
					b_in[i][j]   = WBP'(b[j]);
					acc_in[i][j] = '0;
				end else begin
					a_in[i][j]   = a_s[i-1][j];
					b_in[i][j]   = b_s[i-1][j];
					acc_in[i][j] = acc_s[i-1][j];
				end
				prod[i][j]  = a_in[i][j] * b_in[i][j][i*CH +: CH];
				sum_n[i][j] = acc_in[i][j] + (WP'(prod[i][j]) << (i * CH));
			end
			if (i == 0) begin
				t_in[i] = tag_in;
				v_in[i] = vin;
			end else begin
				t_in[i] = tag_s[i-1];
				v_in[i] = v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < NST; i++) v_s[i] <= v_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) begin
				for (int j = 0; j < N; j++) begin
					a_s[i][j]   <= a_in[i][j];
					b_s[i][j]   <= b_in[i][j];
					acc_s[i][j] <= sum_n[i][j];
				end
				tag_s[i] <= t_in[i];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < N; j++) p[j] = acc_s[NST-1][j];
	end
	assign vout    = v_s[NST-1];
	assign tag_out = tag_s[NST-1];

endmodule

// ===== design/hsct_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_sqrt
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module hsct_sqrt #(
	parameter int W  = 140,
	parameter int WT = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  logic [W-1:0]    rad,
	input  logic [WT-1:0]   tag_in,
	output logic            vout,
	output logic [W/2-1:0]  root,
	output logic [WT-1:0]   tag_out
);
	localparam int R   = W / 2;
	localparam int NST = R;

	logic [R+1:0]  rem_s  [NST];
	logic [R-1:0]  root_s [NST];
	logic [W-1:0]  rad_s  [NST];
	logic [WT-1:0] tag_s  [NST];
	logic          v_s    [NST];

	logic [R+1:0]  rem_in  [NST];
	logic [R-1:0]  root_in [NST];
	logic [W-1:0]  rad_in  [NST];
	logic [WT-1:0] t_in    [NST];
	logic          v_in    [NST];
	logic [R+1:0]  rem_sh  [NST];
	logic [R+1:0]  trial   [NST];
	logic          ge      [NST];

	always_comb begin
		for (int i = 0; i < NST; i++) begin
			if (i == 0) begin
				rem_in[i]  = '0;
				root_in[i] = '0;
				rad_in[i]  = rad;
				t_in[i]    = tag_in;
				v_in[i]    = vin;
			end else begin
				rem_in[i]  = rem_s[i-1];
				root_in[i] = root_s[i-1];
				rad_in[i]  = rad_s[i-1];
				t_in[i]    = tag_s[i-1];
				v_in[i]    = v_s[i-1];
			end
			// bring down the next two radicand bits, try root*4+1
			rem_sh[i] = {rem_in[i][R-1:0], rad_in[i][W-1 -: 2]};
			trial[i]  = {root_in[i], 2'b01};
			ge[i]     = rem_sh[i] >= trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < NST; i++) v_s[i] <= v_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) begin
				rem_s[i]  <= ge[i] ? rem_sh[i] - trial[i] : rem_sh[i];
				root_s[i] <= {root_in[i][R-2:0], ge[i]};
				rad_s[i]  <= rad_in[i] << 2;
				tag_s[i]  <= t_in[i];
			end
		end
	end

	assign vout    = v_s[NST-1];
	assign root    = root_s[NST-1];
	assign tag_out = tag_s[NST-1];

endmodule

// ===== design/hsct_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_div
// Pipelined restoring divider with overflow flag, one quotient bit per stage after the first.
// ----------------------------------------------------------------------------
module hsct_div #(
	parameter int WN = 86,
	parameter int WD = 68,
	parameter int QW = 25,
	parameter int WT = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  logic [WN-1:0]   num,
	input  logic [WD-1:0]   den,
	input  logic [WT-1:0]   tag_in,
	output logic            vout,
	output logic [QW-1:0]   quo,
	output logic            ovf,
	output logic [WT-1:0]   tag_out
);
	localparam int WX  = WD + QW;
	localparam int NST = QW + 1;

	logic [WX-1:0] rem_s [NST];
	logic [WD-1:0] den_s [NST];
	logic [QW-1:0] q_s   [NST];
	logic          ovf_s [NST];
	logic [WT-1:0] tag_s [NST];
	logic          v_s   [NST];

	logic [WX-1:0] rem_n [NST];
	logic [QW-1:0] q_n   [NST];
	logic [WX-1:0] trial [NST];
	logic          ge    [NST];

	always_comb begin
		for (int i = 0; i < NST; i++) begin
			trial[i] = '0;
			ge[i]    = 1'b0;
			if (i == 0) begin
				rem_n[i] = WX'(num);
				q_n[i]   = '0;
			end else begin
				trial[i] = WX'(den_s[i-1]) << (QW - i);
				ge[i]    = rem_s[i-1] >= trial[i];
				rem_n[i] = ge[i] ? rem_s[i-1] - trial[i] : rem_s[i-1];
				q_n[i]   = q_s[i-1];
				q_n[i][QW-i] = ge[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
			for (int i = 1; i < NST; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient would need more than QW bits
			ovf_s[0] <= WX'(num) >= (WX'(den) << QW);
			den_s[0] <= den;
			tag_s[0] <= tag_in;
			for (int i = 1; i < NST; i++) begin
				ovf_s[i] <= ovf_s[i-1];
				den_s[i] <= den_s[i-1];
				tag_s[i] <= tag_s[i-1];
			end
			for (int i = 0; i < NST; i++) begin
				rem_s[i] <= rem_n[i];
				q_s[i]   <= q_n[i];
			end
		end
	end

	assign vout    = v_s[NST-1];
	assign quo     = q_s[NST-1];
	assign ovf     = ovf_s[NST-1];
	assign tag_out = tag_s[NST-1];

endmodule
